>>> rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared codes, field widths and cell control types for the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

  // stream field widths
  localparam int CMD_W       = 3;
  localparam int POS_W       = 6;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int DATA_W      = 32;
  localparam int FOUND_AT_W  = 6;
  localparam int COUNT_NOW_W = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // what every cell does with its entry this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  // what a cell reports into the result wave
  typedef enum logic {
    SCAN_GET,
    SCAN_SEARCH
  } scan_kind_t;

  typedef struct packed {
    cell_op_t   op;
    scan_kind_t kind;
  } cell_ctl_t;

endpackage

>>> rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell
// One list slot: holds an entry, shifts with its neighbors, and joins the
// result wave that runs from slot zero upward.
// ----------------------------------------------------------------------------
module olt_cell #(
  parameter int IDX        = 0,
  parameter int ITEM_WIDTH = 32,
  parameter int CW         = 7,
  parameter int IW         = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  olt_pkg::cell_ctl_t    ctl,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         count,
  input  logic [ITEM_WIDTH-1:0] key,
  input  logic [ITEM_WIDTH-1:0] left_entry,
  input  logic [ITEM_WIDTH-1:0] right_entry,
  output logic [ITEM_WIDTH-1:0] entry,
  input  logic                  hit_in,
  input  logic [IW-1:0]         idx_in,
  input  logic [ITEM_WIDTH-1:0] data_in,
  output logic                  hit_out,
  output logic [IW-1:0]         idx_out,
  output logic [ITEM_WIDTH-1:0] data_out
);

  localparam logic [CW-1:0] MY_POS = CW'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [ITEM_WIDTH-1:0] entry_r;
  logic                  hit_r;
  logic [IW-1:0]         idx_r;
  logic [ITEM_WIDTH-1:0] data_r;
  logic                  match;

  always_comb begin
    case (ctl.kind)
      olt_pkg::SCAN_SEARCH: match = (entry_r == key) && (MY_POS < count);
      default:              match = (MY_POS == pos);
    endcase
  end

  // shift: insert pulls from the left, remove pulls from the right
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      olt_pkg::OP_INSERT: begin
        if (MY_POS > pos) begin
          entry_r <= left_entry;
        end else if (MY_POS == pos) begin
          entry_r <= key;
        end
      end
      olt_pkg::OP_REMOVE: begin
        if (MY_POS >= pos) begin
          entry_r <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // lowest slot wins: pass an earlier hit, else offer this one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_in | match;
    end
    if (!hit_in && match) begin
      idx_r  <= MY_IDX;
      data_r <= entry_r;
    end else begin
      idx_r  <= idx_in;
      data_r <= data_in;
    end
  end

  assign entry    = entry_r;
  assign hit_out  = hit_r;
  assign idx_out  = idx_r;
  assign data_out = data_r;

endmodule

>>> rtl/ordered_list_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Ordered list of up to DEPTH items kept in a row of cells, with append,
// insert, get, remove, search and clear commands and one result per command.
// ----------------------------------------------------------------------------
// Sequence: IDLE, EXEC, then RESP loads the registered result; get, remove
//   and search add SCAN, where the wave crosses the row one cell per cycle.
// Handshake: in_tready is high only in IDLE, so a new command is taken only
//   after RESP has loaded the previous result into the output register.
// Reset: synchronous active-low rst_n empties the list and drops out_tvalid;
//   entry contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_table_unit #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: cmd[2:0], position[8:3], value[40:9], zero fill [47:41]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [olt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: status[1:0], data[33:2], found[34], found_at[40:35],
  //            count_now[47:41]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [olt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SCAN,
    RESP
  } state_t;

  state_t                        state_r;
  logic [olt_pkg::CMD_W-1:0]     cmd_r;
  logic [olt_pkg::POS_W-1:0]     pos_r;
  logic [ITEM_WIDTH-1:0]         key_r;
  logic [CW-1:0]                 count_r;
  logic [IW-1:0]                 scan_cnt_r;
  logic [olt_pkg::STATUS_W-1:0]  res_status_r;
  logic [ITEM_WIDTH-1:0]         res_data_r;
  logic                          res_found_r;
  logic [IW-1:0]                 res_idx_r;
  logic                          out_tvalid_r;
  logic [olt_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                          full;
  logic [PW-1:0]                 pos_ext;
  logic [PW-1:0]                 cnt_ext;
  logic [CW-1:0]                 wr_pos;
  logic                          exec_write;
  logic                          exec_scan;
  logic                          exec_err;
  logic [olt_pkg::STATUS_W-1:0]  exec_status;
  logic                          scan_last;
  olt_pkg::cell_ctl_t            cell_ctl;

  // cell row links
  logic [ITEM_WIDTH-1:0]         entry_c [DEPTH];
  logic                          hit_c   [DEPTH+1];
  logic [IW-1:0]                 idx_c   [DEPTH+1];
  logic [ITEM_WIDTH-1:0]         data_c  [DEPTH+1];

  assign full    = (count_r == CW'(DEPTH));
  assign pos_ext = PW'(pos_r);
  assign cnt_ext = PW'(count_r);
  // append is an insert at the current end
  assign wr_pos  = (cmd_r == olt_pkg::CMD_APPEND) ? count_r : CW'(pos_r);

  // Decode the held command against the current count.
  always_comb begin
    exec_write  = 1'b0;
    exec_scan   = 1'b0;
    exec_status = olt_pkg::ST_OK;
    unique case (cmd_r)
      olt_pkg::CMD_APPEND: begin
        if (full) begin
          exec_status = olt_pkg::ST_FULL;
        end else begin
          exec_write = 1'b1;
        end
      end
      olt_pkg::CMD_INSERT: begin
        // index check comes before the full check
        if (pos_ext > cnt_ext) begin
          exec_status = olt_pkg::ST_RANGE;
        end else if (full) begin
          exec_status = olt_pkg::ST_FULL;
        end else begin
          exec_write = 1'b1;
        end
      end
      olt_pkg::CMD_GET, olt_pkg::CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          exec_status = olt_pkg::ST_RANGE;
        end else begin
          exec_scan = 1'b1;
        end
      end
      olt_pkg::CMD_SEARCH: begin
        exec_scan = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign exec_err  = (exec_status != olt_pkg::ST_OK);
  assign scan_last = (scan_cnt_r == IW'(DEPTH - 1));

  // Drive the cell row: shift on a good insert, close the gap at the end of
  // a remove scan, otherwise hold.
  always_comb begin
    if (state_r == EXEC && exec_write) begin
      cell_ctl.op = olt_pkg::OP_INSERT;
    end else if (state_r == SCAN && scan_last && cmd_r == olt_pkg::CMD_REMOVE) begin
      cell_ctl.op = olt_pkg::OP_REMOVE;
    end else begin
      cell_ctl.op = olt_pkg::OP_HOLD;
    end
    cell_ctl.kind = (cmd_r == olt_pkg::CMD_SEARCH) ? olt_pkg::SCAN_SEARCH
                                                   : olt_pkg::SCAN_GET;
  end

  // The wave enters slot zero empty.
  assign hit_c[0]  = 1'b0;
  assign idx_c[0]  = '0;
  assign data_c[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_e;
    logic [ITEM_WIDTH-1:0] right_e;

    if (g == 0) begin : g_first
      assign left_e = key_r;
    end else begin : g_mid_l
      assign left_e = entry_c[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_e = entry_c[g];
    end else begin : g_mid_r
      assign right_e = entry_c[g+1];
    end

    olt_cell #(
      .IDX        (g),
      .ITEM_WIDTH (ITEM_WIDTH),
      .CW         (CW),
      .IW         (IW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .pos         (wr_pos),
      .count       (count_r),
      .key         (key_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entry_c[g]),
      .hit_in      (hit_c[g]),
      .idx_in      (idx_c[g]),
      .data_in     (data_c[g]),
      .hit_out     (hit_c[g+1]),
      .idx_out     (idx_c[g+1]),
      .data_out    (data_c[g+1])
    );
  end

  // Sequencer: state, count and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the result once the downstream side takes it; RESP reloads it
      if (out_tvalid_r && out_tready && state_r != RESP) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tdata[2:0];
            pos_r   <= in_tdata[8:3];
            key_r   <= ITEM_WIDTH'(in_tdata[40:9]);
            state_r <= EXEC;
          end
        end
        EXEC: begin
          res_status_r <= exec_status;
          res_data_r   <= '0;
          res_found_r  <= 1'b0;
          res_idx_r    <= '0;
          if (exec_write) begin
            count_r <= count_r + 1'b1;
          end else if (cmd_r == olt_pkg::CMD_CLEAR) begin
            count_r <= '0;
          end
          scan_cnt_r <= '0;
          state_r    <= exec_scan ? SCAN : RESP;
        end
        SCAN: begin
          if (scan_last) begin
            // wave has reached the top of the row
            scan_cnt_r <= '0;
            if (cmd_r == olt_pkg::CMD_SEARCH) begin
              res_found_r <= hit_c[DEPTH];
              res_idx_r   <= hit_c[DEPTH] ? idx_c[DEPTH] : '0;
            end else begin
              res_data_r <= data_c[DEPTH];
            end
            if (cmd_r == olt_pkg::CMD_REMOVE) begin
              count_r <= count_r - 1'b1;
            end
            state_r <= RESP;
          end else begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        RESP: begin
          // advance once the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {olt_pkg::COUNT_NOW_W'(count_r),
                             olt_pkg::FOUND_AT_W'(res_idx_r),
                             res_found_r,
                             olt_pkg::DATA_W'(res_data_r),
                             res_status_r};
            out_tvalid_r <= 1'b1;
            state_r      <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("list count above capacity");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EXEC) && exec_err |=> $stable(count_r))
    else $error("refused command changed the count");

  a_found_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RESP) && res_found_r |-> (CW'(res_idx_r) < count_r))
    else $error("search hit at or beyond the list end");

  a_scan_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != SCAN) |-> (scan_cnt_r == '0))
    else $error("scan counter running outside a scan");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == RESP))
    else $error("result presented without a response step");

endmodule

>>> test/ordered_list_table_unit_test.sv
// ----------------------------------------------------------------------------
// ordered_list_table_unit_test
// Self-checking bench for the ordered list table. A shadow copy of the list
// predicts status, data, search hit and count for every command transfer.
// Each result transfer is compared against the oldest prediction. Stimulus
// starts with a directed pass over the corner cases. Random passes follow,
// each opening with a fill to capacity. Sender and receiver throttling
// change from one pass to the next.
// ----------------------------------------------------------------------------
module ordered_list_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 1_000_000;

  // commands 6 and 7 are spare codes the block must treat as no-ops
  localparam logic [olt_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [olt_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // one result, laid out so that status lands in the lowest bits
  typedef struct packed {
    logic [olt_pkg::COUNT_NOW_W-1:0] count_now;
    logic [olt_pkg::FOUND_AT_W-1:0]  found_at;
    logic                            found;
    logic [olt_pkg::DATA_W-1:0]      data;
    logic [olt_pkg::STATUS_W-1:0]    status;
  } list_result_t;

  // Shadow of the list contents plus the queue of results still owed.
  class list_shadow;
    logic [olt_pkg::VALUE_W-1:0] items [LIST_DEPTH];
    int                          held;
    list_result_t                awaited [$];
    int                          errors;

    function new();
      held   = 0;
      errors = 0;
      foreach (items[i]) items[i] = '0;
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Advance the shadow by one accepted command and queue its result.
    function void apply_command(input logic [olt_pkg::CMD_W-1:0] cmd,
                                input logic [olt_pkg::POS_W-1:0] pos,
                                input logic [olt_pkg::VALUE_W-1:0] value);
      list_result_t r;
      int           i;
      int           at;
      r = '0;
      at = int'(pos);
      case (cmd)
        olt_pkg::CMD_APPEND: begin
          if (held >= LIST_DEPTH) begin
            r.status = olt_pkg::ST_FULL;
          end else begin
            items[held] = value;
            held++;
          end
        end
        olt_pkg::CMD_INSERT: begin
          // range check comes before the full check
          if (at > held) begin
            r.status = olt_pkg::ST_RANGE;
          end else if (held >= LIST_DEPTH) begin
            r.status = olt_pkg::ST_FULL;
          end else begin
            for (i = held; i > at; i--) items[i] = items[i-1];
            items[at] = value;
            held++;
          end
        end
        olt_pkg::CMD_GET: begin
          if (at >= held) r.status = olt_pkg::ST_RANGE;
          else r.data = items[at];
        end
        olt_pkg::CMD_REMOVE: begin
          if (at >= held) begin
            r.status = olt_pkg::ST_RANGE;
          end else begin
            r.data = items[at];
            for (i = at + 1; i < held; i++) items[i-1] = items[i];
            held--;
          end
        end
        olt_pkg::CMD_SEARCH: begin
          for (i = held - 1; i >= 0; i--) begin
            if (items[i] == value) begin
              r.found    = 1'b1;
              r.found_at = i[olt_pkg::FOUND_AT_W-1:0];
            end
          end
        end
        olt_pkg::CMD_CLEAR: held = 0;
        default: ;
      endcase
      r.count_now = held[olt_pkg::COUNT_NOW_W-1:0];
      awaited.push_back(r);
    endfunction

    // Compare one result transfer against the oldest owed result.
    task check_result(input logic [olt_pkg::OUT_TDATA_W-1:0] word);
      list_result_t got;
      list_result_t want;
      got = word;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", word));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.data !== want.data || got.found !== want.found ||
          got.found_at !== want.found_at || got.count_now !== want.count_now)
        report_mismatch($sformatf(
          "status %0d/%0d data %h/%h found %0b/%0b found_at %0d/%0d count %0d/%0d (got/want)",
          got.status, want.status, got.data, want.data, got.found, want.found,
          got.found_at, want.found_at, got.count_now, want.count_now));
    endtask

    task check_drained();
      if (awaited.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // cmd[2:0], position[8:3], value[40:9], zero [47:41]
  logic [olt_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // status[1:0], data[33:2], found[34], found_at[40:35], count_now[47:41]
  logic [olt_pkg::OUT_TDATA_W-1:0] out_tdata;

  list_shadow shadow;
  int         send_gap_pct;
  int         recv_gap_pct;
  int         cycles = 0;

  ordered_list_table_unit #(
    .DEPTH     (LIST_DEPTH),
    .ITEM_WIDTH(32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // Throttle the result side: redraw ready on every falling edge.
  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_gap_pct);
  end

  // Sample result transfers on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata);
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ordered_list_table_unit_test: FAIL");
      $finish;
    end
  end

  // Present one command, hold it until the transfer, then feed the shadow.
  // Entered and left at a falling edge; valid stays high for the next call,
  // which drops it only if it decides to idle.
  task automatic send_command(input logic [olt_pkg::CMD_W-1:0] cmd,
                              input logic [olt_pkg::POS_W-1:0] pos,
                              input logic [olt_pkg::VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, value, pos, cmd};
    do @(posedge clk); while (!in_tready);
    shadow.apply_command(cmd, pos, value);
    @(negedge clk);
  endtask

  // Values lean on a small pool so duplicates appear and searches have to
  // pick the lowest matching index; the rest hit the top end or go fully random.
  function automatic logic [olt_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return olt_pkg::VALUE_W'($urandom_range(0, 7));
      1: return 32'hFFFF_FFFF - olt_pkg::VALUE_W'($urandom_range(0, 7));
      default: return olt_pkg::VALUE_W'($urandom());
    endcase
  endfunction

  // Fill the list to capacity, then push against the full list.
  task automatic fill_list(inout int sent);
    while (shadow.held < LIST_DEPTH) begin
      send_command(olt_pkg::CMD_APPEND, olt_pkg::POS_W'($urandom_range(0, 63)), pick_value());
      sent++;
    end
    send_command(olt_pkg::CMD_APPEND, olt_pkg::POS_W'($urandom_range(0, 63)), pick_value());
    send_command(olt_pkg::CMD_INSERT, olt_pkg::POS_W'($urandom_range(0, 63)), pick_value());
    send_command(olt_pkg::CMD_GET, 6'd63, pick_value());
    send_command(olt_pkg::CMD_SEARCH, 6'd0, shadow.items[LIST_DEPTH-1]);
    send_command(olt_pkg::CMD_REMOVE, 6'd63, pick_value());
    sent += 5;
  endtask

  // Random commands, weighted toward growth so the list spends time both
  // near empty and near full; positions mostly land inside the list.
  task automatic run_random(input int quota);
    int                          sent;
    int                          roll;
    int                          top;
    logic [olt_pkg::CMD_W-1:0]   cmd;
    logic [olt_pkg::POS_W-1:0]   pos;
    logic [olt_pkg::VALUE_W-1:0] value;
    sent = 0;
    fill_list(sent);
    while (sent < quota) begin
      if ($urandom_range(0, 59) == 0) begin
        fill_list(sent);
      end else begin
        roll  = $urandom_range(0, 99);
        top   = (shadow.held > 63) ? 63 : shadow.held;
        pos   = ($urandom_range(0, 3) == 0) ? olt_pkg::POS_W'($urandom_range(0, 63))
                                            : olt_pkg::POS_W'($urandom_range(0, top));
        value = pick_value();
        if (roll < 22) cmd = olt_pkg::CMD_APPEND;
        else if (roll < 40) cmd = olt_pkg::CMD_INSERT;
        else if (roll < 55) cmd = olt_pkg::CMD_GET;
        else if (roll < 72) cmd = olt_pkg::CMD_REMOVE;
        else if (roll < 94) cmd = olt_pkg::CMD_SEARCH;
        else if (roll < 96) cmd = olt_pkg::CMD_CLEAR;
        else cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
        // search mostly for something that is actually held
        if (cmd == olt_pkg::CMD_SEARCH && shadow.held > 0 && $urandom_range(0, 9) < 6)
          value = shadow.items[$urandom_range(0, shadow.held - 1)];
        send_command(cmd, pos, value);
        sent++;
      end
    end
  endtask

  initial begin
    shadow       = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    send_gap_pct = 11;
    recv_gap_pct = 84;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty list, boundaries, duplicates, spare codes, clear
    send_command(olt_pkg::CMD_GET,    6'd0,  32'h0000_0000);  // read from empty
    send_command(olt_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000);  // remove from empty
    send_command(olt_pkg::CMD_SEARCH, 6'd0,  32'h0000_0000);  // search in empty
    send_command(olt_pkg::CMD_INSERT, 6'd1,  32'h1111_1111);  // insert past the end
    send_command(olt_pkg::CMD_INSERT, 6'd0,  32'hFFFF_FFFF);  // insert at count appends
    send_command(olt_pkg::CMD_APPEND, 6'd63, 32'h0000_0000);
    send_command(olt_pkg::CMD_APPEND, 6'd0,  32'hFFFF_FFFF);  // duplicate value
    send_command(olt_pkg::CMD_INSERT, 6'd3,  32'h8000_0001);  // insert at count
    send_command(olt_pkg::CMD_INSERT, 6'd1,  32'h5A5A_A5A5);  // insert in the middle
    send_command(olt_pkg::CMD_SEARCH, 6'd63, 32'hFFFF_FFFF);  // lowest of two matches
    send_command(olt_pkg::CMD_SEARCH, 6'd0,  32'h0000_1234);  // miss
    send_command(olt_pkg::CMD_GET,    6'd4,  32'h0000_0000);  // last item
    send_command(olt_pkg::CMD_GET,    6'd5,  32'h0000_0000);  // one past the end
    send_command(olt_pkg::CMD_GET,    6'd63, 32'h0000_0000);
    send_command(olt_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000);  // head, shifts all
    send_command(olt_pkg::CMD_REMOVE, 6'd3,  32'h0000_0000);  // tail
    send_command(olt_pkg::CMD_REMOVE, 6'd63, 32'h0000_0000);  // out of range
    send_command(CMD_SPARE_LO,        6'd63, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_HI,        6'd21, 32'hA5A5_5A5A);
    send_command(olt_pkg::CMD_CLEAR,  6'd0,  32'h0000_0000);
    send_command(olt_pkg::CMD_GET,    6'd0,  32'h0000_0000);  // stale entries stay hidden
    send_command(olt_pkg::CMD_APPEND, 6'd0,  32'h0000_0001);
    send_command(olt_pkg::CMD_SEARCH, 6'd0,  32'h0000_0001);

    // random passes: slow receiver, then slow sender, then full speed
    run_random(376);
    send_gap_pct = 84;
    recv_gap_pct = 11;
    run_random(376);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_random(376);
    in_tvalid = 1'b0;

    // drain, then allow time for any stray extra result to show up
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    shadow.check_drained();
    if (shadow.errors == 0) begin
      $display("ordered_list_table_unit_test: PASS");
    end else begin
      $display("ordered_list_table_unit_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/olt_pkg.sv
rtl/olt_cell.sv
rtl/ordered_list_table_unit.sv
test/ordered_list_table_unit_test.sv
